FILE: hw/rtl/gqv_pkg.sv
// Shared types and constants for the glyph quad vertex generator.
// No dependencies; every other file but gqv_ram imports this package.
`timescale 1ns / 1ps

package gqv_pkg;

    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int unsigned VCNT_W   = 11;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA    = 2'd3;

    localparam logic [30:0] SCALE_RESET = 31'd65536;

    // corner order of the two triangles
    localparam logic [2:0] CORNER_TL  = 3'd0;
    localparam logic [2:0] CORNER_TR  = 3'd1;
    localparam logic [2:0] CORNER_BL  = 3'd2;
    localparam logic [2:0] CORNER_BL2 = 3'd3;
    localparam logic [2:0] CORNER_TR2 = 3'd4;
    localparam logic [2:0] CORNER_BR  = 3'd5;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  char_code;
        logic        first;
        logic signed [31:0] glyph_advance_in;
        logic signed [31:0] glyph_off_x_in;
        logic signed [31:0] glyph_off_y_in;
        logic signed [31:0] glyph_w_in;
        logic signed [31:0] glyph_h_in;
        logic [16:0] tex_u_left_in;
        logic [16:0] tex_u_right_in;
        logic [16:0] tex_v_top_in;
        logic [16:0] tex_v_bottom_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [2:0]  corner;
        logic [VCNT_W-1:0] vertex_count;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] advance;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic signed [31:0] w;
        logic signed [31:0] h;
        logic [16:0] u_left;
        logic [16:0] u_right;
        logic [16:0] v_top;
        logic [16:0] v_bottom;
    } t_glyph;

    typedef struct packed {
        t_glyph      glyph;
        logic        first;
        logic        emit;
        logic [VCNT_W-1:0] base;
    } t_draw;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] xr;
        logic signed [31:0] y0;
        logic signed [31:0] yb;
        logic [16:0] u_left;
        logic [16:0] u_right;
        logic [16:0] v_top;
        logic [16:0] v_bottom;
        logic [VCNT_W-1:0] base;
    } t_quad;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [30:0] scale;
        logic signed [31:0] extra_advance;
    } t_cfg;

endpackage

FILE: hw/rtl/gqv_in_if.sv
// Input channel: valid/ready handshake carrying one command word.
// Depends on gqv_pkg.
`timescale 1ns / 1ps

interface gqv_in_if;
    import gqv_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/gqv_out_if.sv
// Output channel: valid/ready handshake carrying one vertex word.
// Depends on gqv_pkg.
`timescale 1ns / 1ps

interface gqv_out_if;
    import gqv_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/gqv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module gqv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/gqv_front.sv
// Front end: accepts command words, writes the glyph table, looks up glyphs
// for draws and tracks the per-string character count. Uses gqv_pkg, gqv_ram.
`timescale 1ns / 1ps

module gqv_front #(
    parameter int unsigned MAX_CHARS   = 255,
    parameter int unsigned GLYPH_COUNT = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    gqv_in_if.sink                 i_in_ch,
    input  logic [gqv_pkg::Q_CNT_W-1:0] i_q_count,
    output logic                   o_push,
    output gqv_pkg::t_draw         o_push_data
);
    import gqv_pkg::*;

    localparam int unsigned AW = $clog2(GLYPH_COUNT);
    localparam int unsigned CW = $clog2(MAX_CHARS + 1);

    logic          acc;
    logic          is_draw;
    logic          in_range;
    logic [CW-1:0] cnt_eff;
    logic          emit;
    logic [VCNT_W-1:0] n_base;
    logic [$bits(t_glyph)-1:0] wdata;
    logic [$bits(t_glyph)-1:0] rdata;
    t_glyph        wglyph;

    logic          r_s1_valid;
    logic          r_s1_first;
    logic          r_s1_emit;
    logic [VCNT_W-1:0] r_s1_base;
    logic [CW-1:0] r_cnt;

    assign i_in_ch.ready = (i_q_count + Q_CNT_W'(r_s1_valid)) < Q_CNT_W'(Q_DEPTH);
    assign acc      = i_in_ch.valid & i_in_ch.ready;
    assign is_draw  = i_in_ch.data.cmd == CMD_DRAW;
    assign in_range = {1'b0, i_in_ch.data.char_code} < 9'(GLYPH_COUNT);
    assign cnt_eff  = i_in_ch.data.first ? '0 : r_cnt;
    assign emit     = in_range & (cnt_eff < CW'(MAX_CHARS));
    assign n_base   = VCNT_W'({cnt_eff, 2'b00}) + VCNT_W'({cnt_eff, 1'b0});

    always_comb begin
        wglyph.advance  = i_in_ch.data.glyph_advance_in;
        wglyph.off_x    = i_in_ch.data.glyph_off_x_in;
        wglyph.off_y    = i_in_ch.data.glyph_off_y_in;
        wglyph.w        = i_in_ch.data.glyph_w_in;
        wglyph.h        = i_in_ch.data.glyph_h_in;
        wglyph.u_left   = i_in_ch.data.tex_u_left_in;
        wglyph.u_right  = i_in_ch.data.tex_u_right_in;
        wglyph.v_top    = i_in_ch.data.tex_v_top_in;
        wglyph.v_bottom = i_in_ch.data.tex_v_bottom_in;
    end
    assign wdata = wglyph;

    gqv_ram #(
        .WIDTH ($bits(t_glyph)),
        .DEPTH (GLYPH_COUNT)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (acc & ~is_draw & in_range),
        .i_waddr (i_in_ch.data.char_code[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (acc & is_draw),
        .i_raddr (i_in_ch.data.char_code[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_s1_valid <= acc & is_draw & (emit | i_in_ch.data.first);
            if (acc & is_draw) begin
                r_cnt <= emit ? cnt_eff + CW'(1) : cnt_eff;
            end
        end
        r_s1_first <= i_in_ch.data.first;
        r_s1_emit  <= emit;
        r_s1_base  <= n_base;
    end

    assign o_push            = r_s1_valid;
    assign o_push_data.glyph = rdata;
    assign o_push_data.first = r_s1_first;
    assign o_push_data.emit  = r_s1_emit;
    assign o_push_data.base  = r_s1_base;
endmodule

FILE: hw/rtl/gqv_queue.sv
// Short queue of looked-up draw words between front and back end.
// Uses gqv_pkg.
`timescale 1ns / 1ps

module gqv_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  gqv_pkg::t_draw         i_push_data,
    input  logic                   i_pop,
    output logic                   o_head_valid,
    output gqv_pkg::t_draw         o_head,
    output logic [gqv_pkg::Q_CNT_W-1:0] o_count
);
    import gqv_pkg::*;

    t_draw              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    assign do_pop = i_pop & (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push & ~do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop & ~i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];
    assign o_count      = r_count;
endmodule

FILE: hw/rtl/gqv_calc.sv
// Back end arithmetic: scales glyph metrics with one shared multiplier,
// builds the quad corners and advances the pen. Uses gqv_pkg.
`timescale 1ns / 1ps

module gqv_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gqv_pkg::t_cfg  i_cfg,
    input  logic           i_head_valid,
    input  gqv_pkg::t_draw i_head,
    output logic           o_pop,
    output logic           o_quad_valid,
    output gqv_pkg::t_quad o_quad,
    input  logic           i_quad_ready
);
    import gqv_pkg::*;

    localparam logic [2:0] STEP_LAST = 3'd5;

    function automatic logic signed [31:0] sat_scaled(input logic signed [63:0] p);
        logic signed [31:0] res;
        if (&p[63:47] || ~|p[63:47]) begin
            res = p[47:16];
        end else if (p[63]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7fff_ffff;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] res;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            res = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            res = s[31:0];
        end
        return res;
    endfunction

    logic [2:0]         r_step;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_pen;
    logic signed [31:0] r_pa;
    logic signed [31:0] r_x0;
    logic signed [31:0] r_xr;
    logic signed [31:0] r_y0;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic signed [31:0] scl;
    logic signed [31:0] pen_eff;
    logic               busy;
    logic               done;

    always_comb begin
        case (r_step)
            3'd0:    mul_a = i_head.glyph.advance;
            3'd1:    mul_a = i_head.glyph.off_x;
            3'd2:    mul_a = i_head.glyph.w;
            3'd3:    mul_a = i_head.glyph.off_y;
            3'd4:    mul_a = i_head.glyph.h;
            default: mul_a = i_head.glyph.advance;
        endcase
    end

    assign mul_b   = $signed({1'b0, i_cfg.scale});
    assign prod    = mul_a * mul_b;
    assign scl     = sat_scaled(r_prod);
    assign pen_eff = i_head.first ? i_cfg.origin_x : r_pen;
    assign busy    = i_head_valid & i_head.emit;
    assign done    = busy & (r_step == STEP_LAST) & i_quad_ready;

    assign o_pop        = (i_head_valid & ~i_head.emit) | done;
    assign o_quad_valid = busy & (r_step == STEP_LAST);

    always_comb begin
        o_quad.x0       = r_x0;
        o_quad.xr       = r_xr;
        o_quad.y0       = r_y0;
        o_quad.yb       = add_sat(r_y0, scl);
        o_quad.u_left   = i_head.glyph.u_left;
        o_quad.u_right  = i_head.glyph.u_right;
        o_quad.v_top    = i_head.glyph.v_top;
        o_quad.v_bottom = i_head.glyph.v_bottom;
        o_quad.base     = i_head.base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_pen  <= '0;
        end else begin
            if (i_head_valid & ~i_head.emit) begin
                r_pen <= i_cfg.origin_x;
            end else if (busy) begin
                if (r_step == 3'd2) begin
                    r_pen <= add_sat(r_pa, i_cfg.extra_advance);
                end
                if (r_step != STEP_LAST) begin
                    r_step <= r_step + 3'd1;
                end else if (i_quad_ready) begin
                    r_step <= '0;
                end
            end
        end
        if (busy && r_step != STEP_LAST) begin
            r_prod <= prod;
        end
        if (busy) begin
            case (r_step)
                3'd1:    r_pa <= add_sat(pen_eff, scl);
                3'd2:    r_x0 <= add_sat(pen_eff, scl);
                3'd3:    r_xr <= add_sat(r_x0, scl);
                3'd4:    r_y0 <= add_sat(i_cfg.origin_y, scl);
                default: ;
            endcase
        end
    end
endmodule

FILE: hw/rtl/gqv_emit.sv
// Vertex emitter: holds one quad and walks its six corners into a registered
// output word. Uses gqv_pkg and gqv_out_if.
`timescale 1ns / 1ps

module gqv_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_quad_valid,
    input  gqv_pkg::t_quad i_quad,
    output logic           o_quad_ready,
    gqv_out_if.source      o_out_ch
);
    import gqv_pkg::*;

    t_quad             r_rec;
    logic              r_rec_valid;
    logic [2:0]        r_corner;
    logic [VCNT_W-1:0] r_vcnt;
    logic              r_out_valid;
    t_out_word         r_out;

    logic      load_out;
    logic      right;
    logic      bottom;
    logic      take;
    t_out_word n_out;

    assign load_out     = r_rec_valid & (~r_out_valid | o_out_ch.ready);
    assign o_quad_ready = ~r_rec_valid | (load_out & (r_corner == CORNER_BR));
    assign take         = i_quad_valid & o_quad_ready;

    assign right  = (r_corner == CORNER_TR) || (r_corner == CORNER_TR2) ||
                    (r_corner == CORNER_BR);
    assign bottom = (r_corner == CORNER_BL) || (r_corner == CORNER_BL2) ||
                    (r_corner == CORNER_BR);

    always_comb begin
        n_out.pos_x        = right  ? r_rec.xr : r_rec.x0;
        n_out.pos_y        = bottom ? r_rec.yb : r_rec.y0;
        n_out.tex_u        = right  ? r_rec.u_right : r_rec.u_left;
        n_out.tex_v        = bottom ? r_rec.v_bottom : r_rec.v_top;
        n_out.corner       = r_corner;
        n_out.vertex_count = r_vcnt;
        n_out.last         = r_corner == CORNER_BR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_valid <= 1'b0;
            r_corner    <= CORNER_TL;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_rec_valid <= 1'b1;
                r_corner    <= CORNER_TL;
            end else if (load_out) begin
                if (r_corner == CORNER_BR) begin
                    r_rec_valid <= 1'b0;
                    r_corner    <= CORNER_TL;
                end else begin
                    r_corner <= r_corner + 3'd1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_rec  <= i_quad;
            r_vcnt <= i_quad.base + VCNT_W'(1);
        end else if (load_out) begin
            r_vcnt <= r_vcnt + VCNT_W'(1);
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;
endmodule

FILE: hw/rtl/glyph_quad_vertex_generator.sv
// Glyph quad vertex generator top level: configuration registers, front end,
// queue, arithmetic back end and vertex emitter. Uses gqv_pkg and all gqv_* files.
`timescale 1ns / 1ps

// Usage:
//   i_in_ch carries command words. cmd=write stores a glyph entry at char_code;
//   cmd=draw looks the glyph up and produces six vertex words (two triangles)
//   on o_out_ch, with first restarting the pen at origin_x and the count at 0.
//   Draws past MAX_CHARS in a string, and codes outside the table, emit nothing.
//   Glyph writes may follow one another every cycle while i_in_ch.ready is high.
//   A draw is pushed into the queue in the cycle after acceptance; for each
//   character the back end forms five scaling products through one shared
//   32x32 multiplier and the corner sums, then the emitter registers the quad
//   and its first vertex word. The back end computes the next character while
//   the emitter walks the last, giving one vertex per cycle while ready is high.
//   A four-word queue lets input continue while the output stalls; when the
//   receiver holds ready low the output word holds and input stops once the
//   queue is full. Reset clears pen, count, queue and outputs; the glyph table
//   is not cleared and must be written before it is drawn from.
//   Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata;
//   the user must write them only while the block is idle; the block does not enforce it.
module glyph_quad_vertex_generator #(
    parameter int unsigned MAX_CHARS   = 255,
    parameter int unsigned GLYPH_COUNT = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gqv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]                      i_cfg_wdata,
    gqv_in_if.sink                           i_in_ch,
    gqv_out_if.source                        o_out_ch
);
    import gqv_pkg::*;

    t_cfg               r_cfg;
    logic               push;
    t_draw              push_data;
    logic               pop;
    logic               head_valid;
    t_draw              head;
    logic [Q_CNT_W-1:0] q_count;
    logic               quad_valid;
    logic               quad_ready;
    t_quad              quad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.scale         <= SCALE_RESET;
            r_cfg.extra_advance <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_cfg.origin_x      <= i_cfg_wdata;
                CFG_ORIGIN_Y: r_cfg.origin_y      <= i_cfg_wdata;
                CFG_SCALE:    r_cfg.scale         <= i_cfg_wdata[30:0];
                CFG_EXTRA:    r_cfg.extra_advance <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    gqv_front #(
        .MAX_CHARS   (MAX_CHARS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (i_in_ch),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_push_data (push_data)
    );

    gqv_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_count      (q_count)
    );

    gqv_calc u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_quad_valid (quad_valid),
        .o_quad       (quad),
        .i_quad_ready (quad_ready)
    );

    gqv_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_quad_valid (quad_valid),
        .i_quad       (quad),
        .o_quad_ready (quad_ready),
        .o_out_ch     (o_out_ch)
    );
endmodule
